[hdl/sid_pkg.sv]
// ----------------------------------------------------------------------------
// sid_pkg
// Shared widths, constants and stage types of the signed divider core.
// ----------------------------------------------------------------------------
package sid_pkg;

  localparam int DataWidth = 32;
  localparam int Latency   = DataWidth + 2;

  typedef logic [DataWidth-1:0] word_t;

  localparam word_t MaxPos = {1'b0, {(DataWidth-1){1'b1}}};
  localparam word_t MinNeg = {1'b1, {(DataWidth-1){1'b0}}};
  localparam word_t AllOne = {DataWidth{1'b1}};

  typedef struct packed {
    logic  neg;
    logic  sat;
    word_t dvs;
    word_t rem;
    word_t dq;
  } stage_t;

endpackage

[hdl/sid_prep.sv]
// ----------------------------------------------------------------------------
// sid_prep
// Entry stage: operand magnitudes, result sign and saturation flag.
// ----------------------------------------------------------------------------
module sid_prep (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic signed [sid_pkg::DataWidth-1:0] dividend_i,
  input  logic signed [sid_pkg::DataWidth-1:0] divisor_i,
  output logic                           valid_o,
  output sid_pkg::stage_t                stage_o
);
  import sid_pkg::*;

  logic   dvd_neg;
  logic   dvs_neg;
  word_t  dvd_mag;
  word_t  dvs_mag;
  logic   valid_q;
  stage_t stage_d;
  stage_t stage_q;

  assign dvd_neg = dividend_i[DataWidth-1];
  assign dvs_neg = divisor_i[DataWidth-1];
  assign dvd_mag = dvd_neg ? word_t'(-dividend_i) : word_t'(dividend_i);
  assign dvs_mag = dvs_neg ? word_t'(-divisor_i) : word_t'(divisor_i);

  always_comb begin
    stage_d.neg = dvd_neg ^ dvs_neg;
    stage_d.sat = (divisor_i == '0) ||
                  ((word_t'(dividend_i) == MinNeg) && (word_t'(divisor_i) == AllOne));
    stage_d.dvs = dvs_mag;
    stage_d.rem = '0;
    stage_d.dq  = dvd_mag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

[hdl/sid_cell.sv]
// ----------------------------------------------------------------------------
// sid_cell
// One restoring division step: shift in a dividend bit, trial subtract,
// shift in the quotient bit.
// ----------------------------------------------------------------------------
module sid_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  sid_pkg::stage_t stage_i,
  output logic            valid_o,
  output sid_pkg::stage_t stage_o
);
  import sid_pkg::*;

  logic [DataWidth:0] trial;
  logic [DataWidth:0] diff;
  logic               fits;
  logic               valid_q;
  stage_t             stage_d;
  stage_t             stage_q;

  assign trial = {stage_i.rem, stage_i.dq[DataWidth-1]};
  assign diff  = trial - {1'b0, stage_i.dvs};
  assign fits  = !diff[DataWidth];

  always_comb begin
    stage_d     = stage_i;
    stage_d.rem = fits ? diff[DataWidth-1:0] : trial[DataWidth-1:0];
    stage_d.dq  = {stage_i.dq[DataWidth-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

[hdl/sid_post.sv]
// ----------------------------------------------------------------------------
// sid_post
// Exit stage: apply the sign, saturate, register the result beat.
// ----------------------------------------------------------------------------
module sid_post (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  input  sid_pkg::stage_t                      stage_i,
  output logic                                 done_o,
  output logic signed [sid_pkg::DataWidth-1:0] quotient_o
);
  import sid_pkg::*;

  word_t quot_d;
  word_t quot_q;
  logic  done_q;

  always_comb begin
    if (stage_i.sat) begin
      quot_d = MaxPos;
    end else if (stage_i.neg) begin
      quot_d = word_t'(-stage_i.dq);
    end else begin
      quot_d = stage_i.dq;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quot_q;

endmodule

[hdl/signed_integer_divider_core.sv]
// ----------------------------------------------------------------------------
// signed_integer_divider_core
// Pipelined signed 32-bit restoring divider, quotient truncated toward zero.
// Zero divisor and most-negative / -1 give the largest positive value.
// ----------------------------------------------------------------------------
//  beat       ports                                  accepted when
//  ---------  -------------------------------------  -------------------------
//  operands   start_i, dividend_i, divisor_i         start_i && !busy_o
//  quotient   done_o, quotient_o                     every cycle done_o is high
//
//  One operand beat per cycle; busy_o stays low.
//  Pipeline: entry stage, one step cell per quotient bit, then the exit
//  stage; every stage registers its beat.
//  Reset clears the valid bits of all stages; beats in flight are dropped.
//  The result side has no stall: each quotient shows for exactly one cycle.
// ----------------------------------------------------------------------------
module signed_integer_divider_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [sid_pkg::DataWidth-1:0] dividend_i,
  input  logic signed [sid_pkg::DataWidth-1:0] divisor_i,
  output logic                                 done_o,
  output logic signed [sid_pkg::DataWidth-1:0] quotient_o
);
  import sid_pkg::*;

  logic   valid [DataWidth+1];
  stage_t stage [DataWidth+1];

  assign busy_o = 1'b0;

  sid_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (start_i),
    .dividend_i (dividend_i),
    .divisor_i  (divisor_i),
    .valid_o    (valid[0]),
    .stage_o    (stage[0])
  );

  for (genvar k = 0; k < DataWidth; k++) begin : g_cell
    sid_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[k]),
      .stage_i (stage[k]),
      .valid_o (valid[k+1]),
      .stage_o (stage[k+1])
    );
  end

  sid_post u_post (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (valid[DataWidth]),
    .stage_i    (stage[DataWidth]),
    .done_o     (done_o),
    .quotient_o (quotient_o)
  );

endmodule

[hdl/sid_checker.sv]
// ----------------------------------------------------------------------------
// sid_checker
// Port-level checks of the signed divider core: latency, no stall, no early
// result after reset, and the zero-divisor saturation and unit-divisor cases.
// ----------------------------------------------------------------------------
module sid_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 start_i,
  input logic                                 busy_o,
  input logic signed [sid_pkg::DataWidth-1:0] dividend_i,
  input logic signed [sid_pkg::DataWidth-1:0] divisor_i,
  input logic                                 done_o,
  input logic signed [sid_pkg::DataWidth-1:0] quotient_o
);
  import sid_pkg::*;

  localparam int WarmW = $clog2(Latency + 1);
  localparam logic [WarmW-1:0] WarmFull = WarmW'(Latency);

  logic [WarmW-1:0] warm_q;
  logic             warm;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warm_q <= '0;
    end else if (warm_q != WarmFull) begin
      warm_q <= warm_q + 1'b1;
    end
  end

  assign warm = (warm_q == WarmFull);

  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("busy_o raised");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    warm |-> (done_o == $past(start_i && !busy_o, Latency)))
    else $error("result beat not exactly one latency after operand beat");

  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !warm |-> !done_o)
    else $error("result beat before pipeline filled since reset");

  a_zero_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warm && $past(start_i && !busy_o && (divisor_i == '0), Latency))
      |-> (quotient_o == MaxPos))
    else $error("zero divisor did not saturate");

  a_unit_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warm && $past(start_i && !busy_o && (divisor_i == DataWidth'(1)), Latency))
      |-> (quotient_o == $past(dividend_i, Latency)))
    else $error("division by one changed the dividend");

endmodule

bind signed_integer_divider_core sid_checker u_sid_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .dividend_i (dividend_i),
  .divisor_i  (divisor_i),
  .done_o     (done_o),
  .quotient_o (quotient_o)
);

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pipelined signed divider core. Operand beats go
// in with random gaps and back-to-back stretches; every quotient is compared
// against a restoring-division predictor, in order, as it leaves the pipe.
// ----------------------------------------------------------------------------
module tb;

  import sid_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int MaxReports = 10;

  logic  clk_i;
  logic  rst_ni;
  logic  start_i;
  logic  busy_o;
  word_t dividend_i;
  word_t divisor_i;
  logic  done_o;
  word_t quotient_o;

  word_t expected_quotients[$];
  int    mismatch_cnt;
  int    cycle_cnt;
  bit    gaps_on;

  signed_integer_divider_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .dividend_i (dividend_i),
    .divisor_i  (divisor_i),
    .done_o     (done_o),
    .quotient_o (quotient_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic word_t calc_quotient(word_t dvd, word_t dvs);
    word_t mag_dvs;
    word_t mag_dvd;
    word_t quo;
    logic  dvd_neg;
    logic  dvs_neg;
    dvd_neg = dvd[DataWidth-1];
    dvs_neg = dvs[DataWidth-1];
    if (dvs == '0 || (dvd == MinNeg && dvs == AllOne)) begin
      return MaxPos;
    end
    mag_dvs = dvs_neg ? -dvs : dvs;
    mag_dvd = dvd_neg ? -dvd : dvd;
    quo = '0;
    for (int i = DataWidth - 1; i >= 0; i--) begin
      if ((mag_dvd >> i) >= mag_dvs) begin
        quo = {quo[DataWidth-2:0], 1'b1};
        mag_dvd = mag_dvd - (mag_dvs << i);
      end else begin
        quo = {quo[DataWidth-2:0], 1'b0};
      end
    end
    if (dvd_neg != dvs_neg) begin
      quo = -quo;
    end
    return quo;
  endfunction

  // Random magnitude spread over all bit lengths, random sign, some extremes.
  function automatic word_t rand_operand();
    word_t v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0:       v = MinNeg;
      1:       v = MaxPos;
      2:       v = AllOne;
      3:       v = word_t'($urandom_range(0, 3));
      4, 5:    v = v;
      default: v = v >> $urandom_range(0, DataWidth - 1);
    endcase
    if ($urandom_range(0, 1) == 1 && v != MinNeg) begin
      v = -v;
    end
    return v;
  endfunction

  task automatic send_operands(input word_t dvd, input word_t dvs);
    int gap;
    gap = gaps_on ? $urandom_range(0, 6) : 0;
    repeat (gap) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i    <= 1'b1;
    dividend_i <= dvd;
    divisor_i  <= dvs;
    do @(posedge clk_i); while (busy_o);
    expected_quotients.push_back(calc_quotient(dvd, dvs));
  endtask

  task automatic test_special_cases();
    word_t dir_dvd[$];
    word_t dir_dvs[$];
    dir_dvd = '{MinNeg, MinNeg, MinNeg, MaxPos, 32'd0, 32'd0, 32'd0, MinNeg,
                MaxPos, MaxPos, MinNeg, MinNeg, 32'd7, -32'sd7, -32'sd7, 32'd1,
                AllOne, MaxPos, MinNeg, 32'd100, -32'sd100, AllOne, MaxPos};
    dir_dvs = '{32'd1, AllOne, 32'd0, 32'd0, 32'd0, -32'sd5, 32'd5, MinNeg,
                MaxPos, MinNeg, MaxPos, 32'd2, -32'sd2, 32'd2, -32'sd2, MaxPos,
                AllOne, 32'd1, -32'sd2, 32'd100, 32'd3, 32'd1, AllOne};
    foreach (dir_dvd[i]) begin
      send_operands(dir_dvd[i], dir_dvs[i]);
    end
  endtask

  task automatic test_random_spread(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) begin
        gaps_on = ($urandom_range(0, 2) != 0);
      end
      send_operands(rand_operand(), rand_operand());
    end
  endtask

  task automatic test_random_full_words(input int n);
    word_t dvs;
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) begin
        gaps_on = ($urandom_range(0, 2) != 0);
      end
      dvs = $urandom;
      case ($urandom_range(0, 7))
        0:       dvs = '0;
        1:       dvs = AllOne;
        2:       dvs = word_t'($urandom_range(1, 16));
        3:       dvs = -word_t'($urandom_range(1, 16));
        default: dvs = dvs;
      endcase
      send_operands(word_t'($urandom), dvs);
    end
  endtask

  // Check each quotient beat against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_quotients.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MaxReports) begin
          $display("unexpected quotient %0d", $signed(quotient_o));
        end
      end else begin
        if (quotient_o !== expected_quotients[0]) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MaxReports) begin
            $display("quotient mismatch: expected %0d (%h), got %0d (%h)",
                     $signed(expected_quotients[0]), expected_quotients[0],
                     $signed(quotient_o), quotient_o);
          end
        end
        void'(expected_quotients.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    mismatch_cnt = 0;
    cycle_cnt    = 0;
    gaps_on      = 1'b1;
    rst_ni     <= 1'b0;
    start_i    <= 1'b0;
    dividend_i <= '0;
    divisor_i  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_special_cases();
    test_random_spread(500);
    test_random_full_words(330);

    start_i <= 1'b0;
    while (expected_quotients.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);

    if (mismatch_cnt == 0 && expected_quotients.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
